// ----- rtl/core/cpml_pkg.sv -----
// Package with shared widths, codes and defaults of the CPML psi update block.
package cpml_pkg;

  // Field widths of the transaction payloads.
  localparam int DATA_W     = 32;
  localparam int LAYER_W    = 4;
  localparam int CELL_REQ_W = 12;

  // Internal arithmetic widths.
  localparam int DIFF_W   = DATA_W + 1;        // exact field difference
  localparam int SPLIT_W  = 16;                // inv_step is split in two halves
  localparam int PART_W   = DIFF_W + SPLIT_W + 1;
  localparam int GSUM_W   = PART_W + 1;
  localparam int PROD_W   = 2 * DATA_W;        // Q24.40 product
  localparam int TERM_W   = PROD_W + 1;        // product with its sign applied
  localparam int ACC_W    = PROD_W + 2;        // sum of two terms
  localparam int GRAD_SH  = 16;                // Q16.16 scaling of the gradient
  localparam int FRAC_SH  = 24;                // Q8.24 coefficient scaling
  localparam int RECIP_SH = 24;                // reciprocal scaling for cell wrap

  // Defaults of the top-level parameters.
  localparam int LAYER_DEPTH_DEF = 16;
  localparam int CELL_COUNT_DEF  = 4096;

  // Reset value of the reciprocal grid spacing: 1.0 in Q16.16.
  localparam logic [DATA_W-1:0] INV_STEP_RST = 32'h0001_0000;

  // Transaction kinds.
  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_IS_MAGNETIC = 1'b0,
    REG_INV_STEP    = 1'b1
  } cfg_reg_t;

endpackage

// ----- rtl/core/cpml_psi_update.sv -----
// Top level of the CPML auxiliary psi update pipeline.
//
// Channel  Direction  Handshake              Payload
// in       input      start / busy           in_kind, in_layer, in_cell_req, coefficients,
//                                            four field samples
// out      output     out_valid (strobe)     out_cell_out, out_psi_first, out_psi_second
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An update transaction ends in its out_valid strobe, and one update can be accepted in
// every cycle in which busy is low. A load transaction writes the coefficient table at
// acceptance and produces no result. Two updates of the same cell accepted back to back
// stall the front of the pipe: the b*psi multiply and the saturating sum form a
// two-stage loop through the psi store, so the younger update holds in stage four while
// busy is high. After reset busy stays high while the psi store is cleared. The receiver
// cannot stall; every result is on the out ports for one cycle.
module cpml_psi_update #(
  parameter int LAYER_DEPTH = cpml_pkg::LAYER_DEPTH_DEF,
  parameter int CELL_COUNT  = cpml_pkg::CELL_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input transaction
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [cpml_pkg::LAYER_W-1:0]          in_layer,
  input  logic [cpml_pkg::CELL_REQ_W-1:0]       in_cell_req,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_coeff_b,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_coeff_c,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_upper_first,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_lower_first,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_upper_second,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_lower_second,
  // Result transaction
  output logic                                  out_valid,
  output logic [cpml_pkg::CELL_REQ_W-1:0]       out_cell_out,
  output logic signed [cpml_pkg::DATA_W-1:0]    out_psi_first,
  output logic signed [cpml_pkg::DATA_W-1:0]    out_psi_second,
  // Configuration write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [cpml_pkg::DATA_W-1:0]           cfg_data
);
  import cpml_pkg::*;

  localparam int LW = $clog2(LAYER_DEPTH);
  localparam int CW = $clog2(CELL_COUNT);
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int QPROD_W = CELL_REQ_W + RECIP_W;
  localparam int QUOT_W  = QPROD_W - RECIP_SH;
  localparam logic [7:0] DEPTH_C = 8'(LAYER_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'((2 ** RECIP_SH + CELL_COUNT - 1) / CELL_COUNT);
  localparam logic [CELL_REQ_W-1:0] COUNT_C = CELL_REQ_W'(CELL_COUNT);

  // Configuration registers
  logic              is_mag_r;
  logic [DATA_W-1:0] inv_step_r;

  // Handshake and control
  logic          clearing;
  logic          stall;
  logic          adv;
  logic          accept;
  logic [LW-1:0] layer_idx;

  // Pipeline valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  // Stage payloads
  logic [CELL_REQ_W-1:0] req1_r, req2_r, req3_r, req4_r, req5_r, req6_r;
  logic [QUOT_W-1:0]     quot_nxt, quot2_r;
  logic [QPROD_W-1:0]    qprod;
  logic [CELL_REQ_W-1:0] rem_nxt;
  logic [CW-1:0]         cell3_r, cell4_r, cell5_r, cell6_r;
  logic signed [DATA_W-1:0] b1, c1;
  logic signed [DATA_W-1:0] b2_r, c2_r, b3_r, c3_r, b4_r, b5_r;
  logic signed [DATA_W-1:0] g0, g1;
  logic signed [PROD_W-1:0] pc0_nxt, pc1_nxt, pc0_4_r, pc1_4_r;
  logic signed [TERM_W-1:0] qf_nxt, qs_nxt, qf5_r, qs5_r, qf6_r, qs6_r;
  logic                     fwd5_r;
  logic signed [DATA_W-1:0] rd_first, rd_second;
  logic signed [DATA_W-1:0] psi0_s5, psi1_s5;
  logic signed [PROD_W-1:0] pb0_nxt, pb1_nxt, pb0_6_r, pb1_6_r;
  logic signed [ACC_W-1:0]  acc0, acc1;
  logic signed [DATA_W-1:0] n0_nxt, n1_nxt;
  logic [CELL_REQ_W-1:0]    out_cell_r;
  logic signed [DATA_W-1:0] out_first_r, out_second_r;

  // Layer index modulo the table depth, by conditional subtraction.
  function automatic logic [LW-1:0] layer_wrap(input logic [LAYER_W-1:0] l);
    logic [7:0] v;
    v = 8'(l);
    for (int i = 0; i < 8; i++) begin
      if (v >= DEPTH_C) begin
        v = v - DEPTH_C;
      end
    end
    return v[LW-1:0];
  endfunction

  // Floor by 2^24 of the accumulated sum and clamp to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-FRAC_SH-1:0] v;
    logic signed [DATA_W-1:0]        res;
    v   = a[ACC_W-1:FRAC_SH];
    res = v[DATA_W-1:0];
    if (!v[ACC_W-FRAC_SH-1] && (|v[ACC_W-FRAC_SH-2:DATA_W-1])) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[ACC_W-FRAC_SH-1] && !(&v[ACC_W-FRAC_SH-2:DATA_W-1])) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return res;
  endfunction

  // Handshake: a same-cell pair in stages four and five holds the front of the pipe.
  assign stall     = v4_r && v5_r && (cell4_r == cell5_r);
  assign adv       = !stall;
  assign busy      = clearing || stall;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign layer_idx = layer_wrap(in_layer);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_mag_r   <= 1'b0;
      inv_step_r <= INV_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IS_MAGNETIC: is_mag_r   <= cfg_data[0];
        REG_INV_STEP:    inv_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient table: loads write at acceptance, updates read at acceptance.
  cpml_coeff_mem #(
    .LAYER_DEPTH(LAYER_DEPTH)
  ) u_coeff (
    .clk   (clk),
    .wr_en (accept && (in_kind == KIND_LOAD)),
    .rd_en (accept),
    .addr  (layer_idx),
    .wr_b  (in_coeff_b),
    .wr_c  (in_coeff_c),
    .rd_b  (b1),
    .rd_c  (c1)
  );

  // Gradient units for both transverse components, aligned with stage three.
  cpml_grad u_grad_first (
    .clk      (clk),
    .adv      (adv),
    .upper    (in_upper_first),
    .lower    (in_lower_first),
    .inv_step (inv_step_r),
    .grad     (g0)
  );

  cpml_grad u_grad_second (
    .clk      (clk),
    .adv      (adv),
    .upper    (in_upper_second),
    .lower    (in_lower_second),
    .inv_step (inv_step_r),
    .grad     (g1)
  );

  // Cell wrap: reciprocal multiply in stage one, constant multiply and subtract in two.
  always_comb begin
    qprod    = QPROD_W'(req1_r) * QPROD_W'(RECIP_C);
    quot_nxt = qprod[QPROD_W-1:RECIP_SH];
    rem_nxt  = req2_r - CELL_REQ_W'(quot2_r * COUNT_C);
  end

  // Stage three: coupling products with the gradients.
  always_comb begin
    pc0_nxt = c3_r * g0;
    pc1_nxt = c3_r * g1;
  end

  // Stage four: electric and magnetic sign choice on the coupling terms.
  always_comb begin
    qf_nxt = is_mag_r ? TERM_W'(pc1_4_r) : -TERM_W'(pc1_4_r);
    qs_nxt = is_mag_r ? -TERM_W'(pc0_4_r) : TERM_W'(pc0_4_r);
  end

  // Stage five: decay products, with the psi value forwarded from the write-back.
  always_comb begin
    psi0_s5 = fwd5_r ? out_first_r : rd_first;
    psi1_s5 = fwd5_r ? out_second_r : rd_second;
    pb0_nxt = b5_r * psi0_s5;
    pb1_nxt = b5_r * psi1_s5;
  end

  // Stage six: floored, saturated sum of decay and coupling terms.
  always_comb begin
    acc0   = ACC_W'(pb0_6_r) + ACC_W'(qf6_r);
    acc1   = ACC_W'(pb1_6_r) + ACC_W'(qs6_r);
    n0_nxt = sat_acc(acc0);
    n1_nxt = sat_acc(acc1);
  end

  // Psi store: read at stage four's cell, written back from stage six.
  cpml_psi_mem #(
    .CELL_COUNT(CELL_COUNT)
  ) u_psi (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (v6_r),
    .wr_addr   (cell6_r),
    .wr_first  (n0_nxt),
    .wr_second (n1_nxt),
    .rd_addr   (cell4_r),
    .rd_first  (rd_first),
    .rd_second (rd_second),
    .clearing  (clearing)
  );

  // Valid bits: the front four stages hold on a stall, a bubble enters stage five.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= accept && (in_kind == KIND_UPDATE);
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
      v5_r        <= v4_r && adv;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Front stage payloads move only when the pipe advances.
  always_ff @(posedge clk) begin
    if (adv) begin
      req1_r  <= in_cell_req;
      req2_r  <= req1_r;
      quot2_r <= quot_nxt;
      b2_r    <= b1;
      c2_r    <= c1;
      req3_r  <= req2_r;
      cell3_r <= CW'(rem_nxt);
      b3_r    <= b2_r;
      c3_r    <= c2_r;
      req4_r  <= req3_r;
      cell4_r <= cell3_r;
      b4_r    <= b3_r;
      pc0_4_r <= pc0_nxt;
      pc1_4_r <= pc1_nxt;
    end
  end

  // Back stage payloads move every cycle.
  always_ff @(posedge clk) begin
    req5_r       <= req4_r;
    cell5_r      <= cell4_r;
    b5_r         <= b4_r;
    qf5_r        <= qf_nxt;
    qs5_r        <= qs_nxt;
    fwd5_r       <= v6_r && (cell6_r == cell4_r);
    req6_r       <= req5_r;
    cell6_r      <= cell5_r;
    pb0_6_r      <= pb0_nxt;
    pb1_6_r      <= pb1_nxt;
    qf6_r        <= qf5_r;
    qs6_r        <= qs5_r;
    out_cell_r   <= req6_r;
    out_first_r  <= n0_nxt;
    out_second_r <= n1_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_out   = out_cell_r;
  assign out_psi_first  = out_first_r;
  assign out_psi_second = out_second_r;

  // No result leaves while the psi store is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !out_valid_r)
    else $error("result strobe during the psi store clearing pass");

  // A same-cell hold is never followed directly by another hold.
  assert property (@(posedge clk) disable iff (!rst_n) stall |=> !stall)
    else $error("pipeline hold lasted more than one cycle");

  // Adjacent updates in the decay loop never share a cell.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (v5_r && v6_r) |-> (cell5_r != cell6_r))
    else $error("same-cell updates adjacent in the decay loop");

endmodule

// ----- rtl/core/cpml_coeff_mem.sv -----
// Coefficient table holding the decay and coupling coefficients per layer depth.
module cpml_coeff_mem #(
  parameter int LAYER_DEPTH = cpml_pkg::LAYER_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic                                rd_en,
  input  logic [$clog2(LAYER_DEPTH)-1:0]      addr,
  input  logic signed [cpml_pkg::DATA_W-1:0]  wr_b,
  input  logic signed [cpml_pkg::DATA_W-1:0]  wr_c,
  output logic signed [cpml_pkg::DATA_W-1:0]  rd_b,
  output logic signed [cpml_pkg::DATA_W-1:0]  rd_c
);
  import cpml_pkg::*;

  logic [2*DATA_W-1:0] mem [LAYER_DEPTH];
  logic [2*DATA_W-1:0] rd_r;

  // One write and one registered read per cycle, both at the item's layer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {wr_b, wr_c};
    end
    if (rd_en) begin
      rd_r <= mem[addr];
    end
  end

  assign rd_b = $signed(rd_r[2*DATA_W-1:DATA_W]);
  assign rd_c = $signed(rd_r[DATA_W-1:0]);

endmodule

// ----- rtl/core/cpml_psi_mem.sv -----
// Psi store for both transverse components, with a clearing pass after reset.
module cpml_psi_mem #(
  parameter int CELL_COUNT = cpml_pkg::CELL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [$clog2(CELL_COUNT)-1:0]       wr_addr,
  input  logic signed [cpml_pkg::DATA_W-1:0]  wr_first,
  input  logic signed [cpml_pkg::DATA_W-1:0]  wr_second,
  input  logic [$clog2(CELL_COUNT)-1:0]       rd_addr,
  output logic signed [cpml_pkg::DATA_W-1:0]  rd_first,
  output logic signed [cpml_pkg::DATA_W-1:0]  rd_second,
  output logic                                clearing
);
  import cpml_pkg::*;

  localparam int CW = $clog2(CELL_COUNT);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELL_COUNT - 1);

  logic [2*DATA_W-1:0] mem [CELL_COUNT];
  logic [2*DATA_W-1:0] rd_r;
  logic                clear_r;
  logic [CW-1:0]       clr_cnt_r;

  // Clearing pass: one entry per cycle until the last cell is zeroed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      if (clr_cnt_r == LAST_CELL) begin
        clear_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Write port serves the clearing pass first, then the pipeline write-back.
  always_ff @(posedge clk) begin
    if (clear_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_first, wr_second};
    end
  end

  // Registered read every cycle; the pipeline forwards over a same-cycle write.
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  assign rd_first  = $signed(rd_r[2*DATA_W-1:DATA_W]);
  assign rd_second = $signed(rd_r[DATA_W-1:0]);
  assign clearing  = clear_r;

endmodule

// ----- rtl/core/cpml_grad.sv -----
// Three-stage gradient unit: floor((upper - lower) * inv_step / 2^16), saturated.
module cpml_grad (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [cpml_pkg::DATA_W-1:0]  upper,
  input  logic signed [cpml_pkg::DATA_W-1:0]  lower,
  input  logic [cpml_pkg::DATA_W-1:0]         inv_step,
  output logic signed [cpml_pkg::DATA_W-1:0]  grad
);
  import cpml_pkg::*;

  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PART_W-1:0] plo_nxt;
  logic signed [PART_W-1:0] phi_nxt;
  logic signed [PART_W-1:0] plo_r;
  logic signed [PART_W-1:0] phi_r;
  logic signed [GSUM_W-1:0] gsum;
  logic signed [DATA_W-1:0] grad_nxt;
  logic signed [DATA_W-1:0] grad_r;

  // Clamp the wide gradient sum to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat_grad(input logic signed [GSUM_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    res = v[DATA_W-1:0];
    if (!v[GSUM_W-1] && (|v[GSUM_W-2:DATA_W-1])) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[GSUM_W-1] && !(&v[GSUM_W-2:DATA_W-1])) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return res;
  endfunction

  // Stage one: exact difference of the two samples.
  assign diff_nxt = $signed({upper[DATA_W-1], upper}) - $signed({lower[DATA_W-1], lower});

  // Stage two: partial products against the low and high halves of inv_step.
  always_comb begin
    plo_nxt = diff_r * $signed({1'b0, inv_step[SPLIT_W-1:0]});
    phi_nxt = diff_r * $signed({1'b0, inv_step[DATA_W-1:SPLIT_W]});
  end

  // Stage three: diff*hi + floor(diff*lo / 2^16) is the floored quotient.
  always_comb begin
    gsum     = GSUM_W'(phi_r) + GSUM_W'(plo_r >>> GRAD_SH);
    grad_nxt = sat_grad(gsum);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r <= diff_nxt;
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      grad_r <= grad_nxt;
    end
  end

  assign grad = grad_r;

endmodule

// ----- tb/sv/cpml_psi_checker.sv -----
// Checker that predicts and compares the results of the CPML psi update block.
`timescale 1ns / 1ps

module cpml_psi_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  in_kind,
  input  logic [cpml_pkg::LAYER_W-1:0]          in_layer,
  input  logic [cpml_pkg::CELL_REQ_W-1:0]       in_cell_req,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_coeff_b,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_coeff_c,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_upper_first,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_lower_first,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_upper_second,
  input  logic signed [cpml_pkg::DATA_W-1:0]    in_lower_second,
  input  logic                                  out_valid,
  input  logic [cpml_pkg::CELL_REQ_W-1:0]       out_cell_out,
  input  logic signed [cpml_pkg::DATA_W-1:0]    out_psi_first,
  input  logic signed [cpml_pkg::DATA_W-1:0]    out_psi_second,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [cpml_pkg::DATA_W-1:0]           cfg_data,
  output int                                    mismatches,
  output int                                    outstanding
);
  import cpml_pkg::*;

  localparam int NUM_LAYERS = LAYER_DEPTH_DEF;
  localparam int NUM_CELLS  = CELL_COUNT_DEF;
  localparam int WIDE_W     = ACC_W;

  localparam logic signed [WIDE_W-1:0] Q16_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] Q16_MIN = -66'sd2147483648;

  // One expected result transaction.
  typedef struct {
    logic [CELL_REQ_W-1:0]     cell_addr;
    logic signed [DATA_W-1:0]  first;
    logic signed [DATA_W-1:0]  second;
  } psi_result_t;

  // Mirror of the block's state and configuration.
  logic signed [DATA_W-1:0] decay_tbl    [NUM_LAYERS];
  logic signed [DATA_W-1:0] coupling_tbl [NUM_LAYERS];
  logic signed [DATA_W-1:0] psi_first_mem  [NUM_CELLS];
  logic signed [DATA_W-1:0] psi_second_mem [NUM_CELLS];
  logic                     magnetic_mode;
  logic [DATA_W-1:0]        inv_step_reg;

  psi_result_t expected_psi_q[$];
  int fail_total    = 0;
  int pending_total = 0;

  assign mismatches  = fail_total;
  assign outstanding = pending_total;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns psi checker: %s", $time, msg);
    fail_total = fail_total + 1;
  endtask

  // Saturate a wide signed value to the signed Q16.16 range.
  function automatic logic signed [DATA_W-1:0] clamp_q16(input logic signed [WIDE_W-1:0] v);
    if (v > Q16_MAX) begin
      return Q16_MAX[DATA_W-1:0];
    end
    if (v < Q16_MIN) begin
      return Q16_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // Scaled field gradient: floor((upper - lower) * inv_step / 2^16), saturated.
  function automatic logic signed [DATA_W-1:0] field_gradient(
    input logic signed [DATA_W-1:0] upper,
    input logic signed [DATA_W-1:0] lower
  );
    logic signed [WIDE_W-1:0] up_ext;
    logic signed [WIDE_W-1:0] lo_ext;
    logic signed [WIDE_W-1:0] step_ext;
    logic signed [WIDE_W-1:0] scaled;
    up_ext   = upper;
    lo_ext   = lower;
    step_ext = {{(WIDE_W-DATA_W){1'b0}}, inv_step_reg};
    scaled   = (up_ext - lo_ext) * step_ext;
    return clamp_q16(scaled >>> GRAD_SH);
  endfunction

  // Compute both new psi values of a cell and write them back to the mirror store.
  function automatic psi_result_t predict_psi_update(
    input logic [LAYER_W-1:0]    layer,
    input logic [CELL_REQ_W-1:0] cell_req,
    input logic signed [DATA_W-1:0] upper_first,
    input logic signed [DATA_W-1:0] lower_first,
    input logic signed [DATA_W-1:0] upper_second,
    input logic signed [DATA_W-1:0] lower_second
  );
    psi_result_t res;
    logic signed [WIDE_W-1:0] b_ext;
    logic signed [WIDE_W-1:0] c_ext;
    logic signed [WIDE_W-1:0] grad_first;
    logic signed [WIDE_W-1:0] grad_second;
    logic signed [WIDE_W-1:0] psi_a;
    logic signed [WIDE_W-1:0] psi_b;
    logic signed [WIDE_W-1:0] decay_first;
    logic signed [WIDE_W-1:0] decay_second;
    logic signed [WIDE_W-1:0] couple_first;
    logic signed [WIDE_W-1:0] couple_second;
    logic signed [WIDE_W-1:0] sum_first;
    logic signed [WIDE_W-1:0] sum_second;
    b_ext       = decay_tbl[layer];
    c_ext       = coupling_tbl[layer];
    grad_first  = field_gradient(upper_first, lower_first);
    grad_second = field_gradient(upper_second, lower_second);
    psi_a       = psi_first_mem[cell_req];
    psi_b       = psi_second_mem[cell_req];

    // Exact Q24.40 products.
    decay_first   = b_ext * psi_a;
    decay_second  = b_ext * psi_b;
    couple_first  = c_ext * grad_first;
    couple_second = c_ext * grad_second;

    // The magnetic side reverses both coupling signs.
    if (magnetic_mode) begin
      sum_first  = decay_first + couple_second;
      sum_second = decay_second - couple_first;
    end else begin
      sum_first  = decay_first - couple_second;
      sum_second = decay_second + couple_first;
    end

    res.cell_addr = cell_req;
    res.first     = clamp_q16(sum_first >>> FRAC_SH);
    res.second    = clamp_q16(sum_second >>> FRAC_SH);
    psi_first_mem[cell_req]  = res.first;
    psi_second_mem[cell_req] = res.second;
    return res;
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin : watch_channels
    int i;
    psi_result_t want;
    if (!rst_n) begin
      for (i = 0; i < NUM_CELLS; i++) begin
        psi_first_mem[i]  = '0;
        psi_second_mem[i] = '0;
      end
      for (i = 0; i < NUM_LAYERS; i++) begin
        decay_tbl[i]    = '0;
        coupling_tbl[i] = '0;
      end
      magnetic_mode = 1'b0;
      inv_step_reg  = INV_STEP_RST;
      expected_psi_q.delete();
      pending_total <= 0;
    end else begin
      // The sender must make register writes only while the block is idle; the block does not enforce it.
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == REG_IS_MAGNETIC) begin
          magnetic_mode = cfg_data[0];
        end else begin
          inv_step_reg = cfg_data;
        end
      end

      // Compare a result transaction with the oldest expectation.
      if (out_valid) begin
        if (expected_psi_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result for cell %0d", out_cell_out));
        end else begin
          want = expected_psi_q.pop_front();
          if (out_cell_out !== want.cell_addr) begin
            report_mismatch($sformatf("cell_out got %0d, expected %0d",
                                      out_cell_out, want.cell_addr));
          end
          if (out_psi_first !== want.first) begin
            report_mismatch($sformatf("cell %0d psi_first got %h, expected %h",
                                      want.cell_addr, out_psi_first, want.first));
          end
          if (out_psi_second !== want.second) begin
            report_mismatch($sformatf("cell %0d psi_second got %h, expected %h",
                                      want.cell_addr, out_psi_second, want.second));
          end
        end
      end

      // An accepted input transaction either loads coefficients or updates a cell.
      if (start && !busy) begin
        if (kind_t'(in_kind) == KIND_LOAD) begin
          decay_tbl[in_layer]    = in_coeff_b;
          coupling_tbl[in_layer] = in_coeff_c;
        end else begin
          expected_psi_q.push_back(predict_psi_update(in_layer, in_cell_req,
                                                      in_upper_first, in_lower_first,
                                                      in_upper_second, in_lower_second));
        end
      end
      pending_total <= expected_psi_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the testbench: clock, reset, stimulus and verdict for the CPML psi update block.
`timescale 1ns / 1ps

module tb_top;
  import cpml_pkg::*;

  localparam int ITEMS_PER_PHASE = 90;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_TAIL      = 12;

  localparam logic [DATA_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_NEG_MAX = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q8_ONE    = 32'h0100_0000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        start           = 1'b0;
  logic                        busy;
  logic                        in_kind         = 1'b0;
  logic [LAYER_W-1:0]          in_layer        = '0;
  logic [CELL_REQ_W-1:0]       in_cell_req     = '0;
  logic signed [DATA_W-1:0]    in_coeff_b      = '0;
  logic signed [DATA_W-1:0]    in_coeff_c      = '0;
  logic signed [DATA_W-1:0]    in_upper_first  = '0;
  logic signed [DATA_W-1:0]    in_lower_first  = '0;
  logic signed [DATA_W-1:0]    in_upper_second = '0;
  logic signed [DATA_W-1:0]    in_lower_second = '0;
  logic                        out_valid;
  logic [CELL_REQ_W-1:0]       out_cell_out;
  logic signed [DATA_W-1:0]    out_psi_first;
  logic signed [DATA_W-1:0]    out_psi_second;
  logic                        cfg_valid       = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index       = 1'b0;
  logic [DATA_W-1:0]           cfg_data        = '0;

  int mismatches;
  int outstanding;

  // Layers whose coefficients have been loaded; only those may be updated.
  logic [LAYER_DEPTH_DEF-1:0] loaded_layers = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpml_psi_update dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_layer        (in_layer),
    .in_cell_req     (in_cell_req),
    .in_coeff_b      (in_coeff_b),
    .in_coeff_c      (in_coeff_c),
    .in_upper_first  (in_upper_first),
    .in_lower_first  (in_lower_first),
    .in_upper_second (in_upper_second),
    .in_lower_second (in_lower_second),
    .out_valid       (out_valid),
    .out_cell_out    (out_cell_out),
    .out_psi_first   (out_psi_first),
    .out_psi_second  (out_psi_second),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  cpml_psi_checker psi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_layer        (in_layer),
    .in_cell_req     (in_cell_req),
    .in_coeff_b      (in_coeff_b),
    .in_coeff_c      (in_coeff_c),
    .in_upper_first  (in_upper_first),
    .in_lower_first  (in_lower_first),
    .in_upper_second (in_upper_second),
    .in_lower_second (in_lower_second),
    .out_valid       (out_valid),
    .out_cell_out    (out_cell_out),
    .out_psi_first   (out_psi_first),
    .out_psi_second  (out_psi_second),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Field sample: full range, small, or an extreme or zero.
  function automatic logic [DATA_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: begin
        case ($urandom_range(0, 2))
          0: return Q_POS_MAX;
          1: return Q_NEG_MAX;
          default: return '0;
        endcase
      end
      default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  // Coefficient: full range, near one, small, or an extreme.
  function automatic logic [DATA_W-1:0] rand_coeff();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return Q8_ONE - $urandom_range(0, 32'h0020_0000);
      2: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      default: return $urandom_range(0, 1) ? Q_POS_MAX : Q_NEG_MAX;
    endcase
  endfunction

  // Cell address: mostly a few hot cells so the store is revisited.
  function automatic logic [CELL_REQ_W-1:0] rand_cell();
    case ($urandom_range(0, 3))
      0, 1: return CELL_REQ_W'($urandom_range(0, 15));
      2: return CELL_REQ_W'($urandom);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Offer one input transaction after any idle gap and wait until it is accepted.
  task automatic issue_item(
    input kind_t                   kind,
    input logic [LAYER_W-1:0]      layer,
    input logic [CELL_REQ_W-1:0]   cell_addr,
    input logic [DATA_W-1:0]       coeff_b,
    input logic [DATA_W-1:0]       coeff_c,
    input logic [DATA_W-1:0]       upper_first,
    input logic [DATA_W-1:0]       lower_first,
    input logic [DATA_W-1:0]       upper_second,
    input logic [DATA_W-1:0]       lower_second,
    input int                      gap
  );
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= kind;
    in_layer        <= layer;
    in_cell_req     <= cell_addr;
    in_coeff_b      <= coeff_b;
    in_coeff_c      <= coeff_c;
    in_upper_first  <= upper_first;
    in_lower_first  <= lower_first;
    in_upper_second <= upper_second;
    in_lower_second <= lower_second;
    do @(posedge clk); while (busy);
    if (kind == KIND_LOAD) begin
      loaded_layers[layer] = 1'b1;
    end
  endtask

  // Stop sending and wait until every expected result has arrived, then let the pipe settle.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Write one register; cfg_valid is left high for a following write.
  task automatic write_register(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int gap;
    bit burst;
    kind_t kind;
    logic [LAYER_W-1:0] layer;
    logic [DATA_W-1:0] step_value;

    // Synchronous reset, then the block clears its psi store while busy.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset configuration: extreme coefficients,
    // saturating gradients, back-to-back updates of one cell, edge cells,
    // a zero gradient, zero coefficients and a coefficient reload.
    issue_item(KIND_LOAD, 4'd0, '0, Q_POS_MAX, Q_NEG_MAX, $urandom, $urandom, $urandom,
               $urandom, 0);
    issue_item(KIND_LOAD, 4'd15, '1, Q_NEG_MAX, Q_POS_MAX, $urandom, $urandom, $urandom,
               $urandom, 0);
    issue_item(KIND_LOAD, 4'd5, 12'd7, Q8_ONE, 32'h0080_0000, $urandom, $urandom,
               $urandom, $urandom, 0);
    issue_item(KIND_LOAD, 4'd3, 12'd9, '0, '0, $urandom, $urandom, $urandom, $urandom, 0);
    issue_item(KIND_UPDATE, 4'd5, 12'd0, $urandom, $urandom, Q_POS_MAX, Q_NEG_MAX,
               Q_NEG_MAX, Q_POS_MAX, 0);
    issue_item(KIND_UPDATE, 4'd5, 12'd0, $urandom, $urandom, Q_POS_MAX, Q_NEG_MAX,
               Q_NEG_MAX, Q_POS_MAX, 0);
    issue_item(KIND_UPDATE, 4'd0, 12'd0, $urandom, $urandom, 32'h0001_0000, '0,
               '0, 32'h0001_0000, 0);
    issue_item(KIND_UPDATE, 4'd15, 12'hFFF, $urandom, $urandom, '0, '0, 32'd1, '0, 0);
    issue_item(KIND_UPDATE, 4'd15, 12'hFFF, $urandom, $urandom, Q_NEG_MAX, Q_POS_MAX,
               Q_POS_MAX, Q_NEG_MAX, 0);
    issue_item(KIND_UPDATE, 4'd3, 12'd100, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, 2);
    issue_item(KIND_UPDATE, 4'd5, 12'hFFF, $urandom, $urandom, Q_POS_MAX, Q_POS_MAX,
               Q_NEG_MAX, Q_NEG_MAX, 0);
    issue_item(KIND_LOAD, 4'd5, 12'd0, 32'h00F0_0000, 32'hFF00_0000, $urandom, $urandom,
               $urandom, $urandom, 0);
    issue_item(KIND_UPDATE, 4'd5, 12'd0, $urandom, $urandom, 32'h0003_0000, 32'h0001_8000,
               32'hFFFE_0000, 32'h0000_4000, 0);
    issue_item(KIND_UPDATE, 4'd0, 12'd0, $urandom, $urandom, Q_POS_MAX, '0, '0,
               Q_POS_MAX, 1);
    issue_item(KIND_UPDATE, 4'd15, 12'h800, $urandom, $urandom, Q_NEG_MAX, '0,
               Q_POS_MAX, '0, 0);
    issue_item(KIND_UPDATE, 4'd5, 12'h800, $urandom, $urandom, 32'h0000_0100,
               32'hFFFF_FF00, 32'h0000_8000, 32'h0000_0001, 3);

    // Random part in phases, each under its own configuration.
    burst = 1'b0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: step_value = 32'h0001_0000;
        1: step_value = '0;
        2: step_value = '1;
        3: step_value = $urandom;
        4: step_value = $urandom_range(0, 32'h0008_0000);
        default: step_value = 32'h0001_0000;
      endcase

      // The sender waits for all outstanding results before reconfiguring.
      drain_results();
      write_register(REG_IS_MAGNETIC, {31'd0, phase[0] ^ 1'b1});
      write_register(REG_INV_STEP, step_value);
      cfg_valid <= 1'b0;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Alternate between back-to-back bursts and random gaps.
        if ($urandom_range(0, 19) == 0) begin
          burst = !burst;
        end
        gap = burst ? 0 : $urandom_range(0, 8);

        kind = ($urandom_range(0, 9) < 2) ? KIND_LOAD : KIND_UPDATE;
        if (kind == KIND_LOAD) begin
          layer = LAYER_W'($urandom_range(0, LAYER_DEPTH_DEF - 1));
        end else begin
          do layer = LAYER_W'($urandom_range(0, LAYER_DEPTH_DEF - 1));
          while (!loaded_layers[layer]);
        end
        issue_item(kind, layer, rand_cell(), rand_coeff(), rand_coeff(), rand_sample(),
                   rand_sample(), rand_sample(), rand_sample(), gap);
      end
    end

    // Wait for the last results, then give the verdict.
    drain_results();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
